@@ hw/rtl/mcsr_pkg.sv @@
// Shared constants and types for the multi-channel setpoint ramp.
// No dependencies; used by mcsr_slew and multi_channel_setpoint_ramp.
package mcsr_pkg;

  localparam int unsigned NumChannels = 5;
  localparam int unsigned NumPins     = 4;

  localparam int unsigned ValueW = 32;
  localparam int unsigned BaseW  = 16;
  localparam int unsigned ExtraW = 14;
  localparam int unsigned StepW  = 17;   // base + largest extra
  localparam int unsigned CountW = 32;

  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [BaseW-1:0] BaseStepReset = 16'd400;

  // word index of each configuration register
  localparam logic [0:0] RegBaseStep = 1'b0;

  typedef logic [ExtraW-1:0] extra_t;

  // per-channel extras on top of base_step
  localparam extra_t UpExtra   [NumChannels] = '{14'd0, 14'd0, 14'd0, 14'd160, 14'd8600};
  localparam extra_t DownExtra [NumChannels] = '{14'd0, 14'd0, 14'd160, 14'd0, 14'd8500};

  typedef logic signed [ValueW-1:0] value_t;

endpackage

@@ hw/rtl/multi_channel_setpoint_ramp.sv @@
// Top level of the multi-channel setpoint ramp with error-pin counters.
// Depends on mcsr_pkg and mcsr_slew.
//
// Each accepted item is one control tick. It is latched in an input register,
// then, once the output register is free, five slew units move each channel's
// ramp toward its target (clamped at the target, restarted from zero on a
// changed target when restart_on_change is set) and four wrapping counters
// count high error pins. Ramps, previous targets and counts are held in
// flip-flops and the result is placed in an output register, which drives
// out_valid_o; a stalled output holds the item in the input register. One item
// per cycle is sustained while the output is not stalled; the add-compare-clamp
// in each slew unit is combinational. in_stall_o rises only when both the input
// register and the output register are full and the output is stalled.
// base_step (reset 400) lives at byte address 0 of the APB port; write it only
// while the block is idle.
module multi_channel_setpoint_ramp (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mcsr_pkg::ApbAddrW-1:0]    paddr,
  input  logic [mcsr_pkg::ApbDataW-1:0]    pwdata,
  output logic [mcsr_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [31:0]               target_0_i,
  input  logic signed [31:0]               target_1_i,
  input  logic signed [31:0]               target_2_i,
  input  logic signed [31:0]               target_3_i,
  input  logic signed [31:0]               target_4_i,
  input  logic                             restart_on_change_i,
  input  logic                             err_pin_tx1_i,
  input  logic                             err_pin_rx1_i,
  input  logic                             err_pin_tx2_i,
  input  logic                             err_pin_rx2_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [31:0]               ramp_0_o,
  output logic signed [31:0]               ramp_1_o,
  output logic signed [31:0]               ramp_2_o,
  output logic signed [31:0]               ramp_3_o,
  output logic signed [31:0]               ramp_4_o,
  output logic [31:0]                      count_tx1_o,
  output logic [31:0]                      count_rx1_o,
  output logic [31:0]                      count_tx2_o,
  output logic [31:0]                      count_rx2_o
);

  localparam int unsigned Nch  = mcsr_pkg::NumChannels;
  localparam int unsigned Npin = mcsr_pkg::NumPins;

  // ---------------- configuration ----------------
  logic [mcsr_pkg::BaseW-1:0] base_step_q;
  logic [0:0]                 reg_idx;
  logic                       cfg_wr;

  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_step_q <= mcsr_pkg::BaseStepReset;
    end else if (cfg_wr && (reg_idx == mcsr_pkg::RegBaseStep)) begin
      base_step_q <= pwdata[mcsr_pkg::BaseW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      mcsr_pkg::RegBaseStep: prdata = mcsr_pkg::ApbDataW'(base_step_q);
      default:               prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_adv;
  logic in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------- input register ----------------
  mcsr_pkg::value_t  tgt_q [Nch];
  logic              restart_q;
  logic [Npin-1:0]   pins_q;
  mcsr_pkg::value_t  tgt_in [Nch];

  assign tgt_in[0] = target_0_i;
  assign tgt_in[1] = target_1_i;
  assign tgt_in[2] = target_2_i;
  assign tgt_in[3] = target_3_i;
  assign tgt_in[4] = target_4_i;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tgt_q     <= tgt_in;
      restart_q <= restart_on_change_i;
      pins_q    <= {err_pin_rx2_i, err_pin_tx2_i, err_pin_rx1_i, err_pin_tx1_i};
    end
  end

  // ---------------- tick state and slew ----------------
  mcsr_pkg::value_t           ramp_q   [Nch];
  mcsr_pkg::value_t           prev_q   [Nch];
  mcsr_pkg::value_t           ramp_d   [Nch];
  logic [mcsr_pkg::CountW-1:0] count_q [Npin];
  logic [mcsr_pkg::CountW-1:0] count_d [Npin];

  for (genvar c = 0; c < Nch; c++) begin : g_ch
    mcsr_slew u_slew (
      .ramp_i        (ramp_q[c]),
      .prev_target_i (prev_q[c]),
      .target_i      (tgt_q[c]),
      .restart_i     (restart_q),
      .base_step_i   (base_step_q),
      .up_extra_i    (mcsr_pkg::UpExtra[c]),
      .down_extra_i  (mcsr_pkg::DownExtra[c]),
      .ramp_o        (ramp_d[c])
    );
  end

  for (genvar p = 0; p < Npin; p++) begin : g_pin
    // wraps modulo 2^32
    assign count_d[p] = count_q[p] + mcsr_pkg::CountW'(pins_q[p]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < Nch; c++) begin
        ramp_q[c] <= '0;
        prev_q[c] <= '0;
      end
      for (int p = 0; p < Npin; p++) begin
        count_q[p] <= '0;
      end
    end else if (s1_adv) begin
      ramp_q  <= ramp_d;
      prev_q  <= tgt_q;
      count_q <= count_d;
    end
  end

  // ---------------- result register ----------------
  mcsr_pkg::value_t            res_ramp_q  [Nch];
  logic [mcsr_pkg::CountW-1:0] res_count_q [Npin];

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_ramp_q  <= ramp_d;
      res_count_q <= count_d;
    end
  end

  assign ramp_0_o    = res_ramp_q[0];
  assign ramp_1_o    = res_ramp_q[1];
  assign ramp_2_o    = res_ramp_q[2];
  assign ramp_3_o    = res_ramp_q[3];
  assign ramp_4_o    = res_ramp_q[4];
  assign count_tx1_o = res_count_q[0];
  assign count_rx1_o = res_count_q[1];
  assign count_tx2_o = res_count_q[2];
  assign count_rx2_o = res_count_q[3];

endmodule

@@ hw/rtl/mcsr_slew.sv @@
// One channel of the setpoint ramp: restart check, step and clamp.
// Depends on mcsr_pkg.
module mcsr_slew (
  input  mcsr_pkg::value_t               ramp_i,
  input  mcsr_pkg::value_t               prev_target_i,
  input  mcsr_pkg::value_t               target_i,
  input  logic                           restart_i,
  input  logic [mcsr_pkg::BaseW-1:0]     base_step_i,
  input  mcsr_pkg::extra_t               up_extra_i,
  input  mcsr_pkg::extra_t               down_extra_i,
  output mcsr_pkg::value_t               ramp_o
);

  localparam int unsigned WideW = mcsr_pkg::ValueW + 2;

  mcsr_pkg::value_t              start;
  logic [mcsr_pkg::StepW-1:0]    up_step;
  logic [mcsr_pkg::StepW-1:0]    down_step;
  logic signed [WideW-1:0]       start_w;
  logic signed [WideW-1:0]       target_w;
  logic signed [WideW-1:0]       up_w;
  logic signed [WideW-1:0]       down_w;

  // changed target with restart set: ramp starts again from zero
  assign start = (restart_i && (prev_target_i != target_i)) ? '0 : ramp_i;

  assign up_step   = mcsr_pkg::StepW'(base_step_i) + mcsr_pkg::StepW'(up_extra_i);
  assign down_step = mcsr_pkg::StepW'(base_step_i) + mcsr_pkg::StepW'(down_extra_i);

  assign start_w  = WideW'(start);
  assign target_w = WideW'(target_i);
  assign up_w     = start_w + $signed({1'b0, up_step});
  assign down_w   = start_w - $signed({1'b0, down_step});

  always_comb begin
    ramp_o = start;
    if (start < target_i) begin
      ramp_o = (up_w > target_w) ? target_i : up_w[mcsr_pkg::ValueW-1:0];
    end else if (start > target_i) begin
      ramp_o = (down_w < target_w) ? target_i : down_w[mcsr_pkg::ValueW-1:0];
    end
  end

endmodule
